[src/lfbc_pkg.sv]
// ----------------------------------------------------------------------------
// lfbc_pkg
// Shared types and constants of the LED blink and fade controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lfbc_pkg;

    localparam int TIME_WIDTH_DEF  = 16;
    localparam int ALPHA_WIDTH_DEF = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_DUR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVISIBLE_DUR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_DUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_DUR = 3'd4;

    // reset values of the durations
    localparam int VISIBLE_RESET   = 60;
    localparam int INVISIBLE_RESET = 60;
    localparam int FADE_IN_RESET   = 30;
    localparam int FADE_OUT_RESET  = 30;

    typedef enum logic [1:0] {
        PH_VISIBLE   = 2'd0,
        PH_FADE_OUT  = 2'd1,
        PH_INVISIBLE = 2'd2,
        PH_FADE_IN   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUB,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[src/lfbc_sersub.sv]
// ----------------------------------------------------------------------------
// lfbc_sersub
// Bit-serial subtractor: a - b, one bit per cycle, lsb first.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbc_sersub #(
    parameter int W = 17
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_done,
    output logic [W-1:0]      o_diff
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_d;
    logic             r_borrow;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic             s_bit;
    logic             s_borrow;

    assign s_bit    = r_a[0] ^ r_b[0] ^ r_borrow;
    assign s_borrow = (~r_a[0] & r_b[0]) | (~(r_a[0] ^ r_b[0]) & r_borrow);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_borrow <= 1'b0;
        end else if (r_cnt != '0) begin
            r_a      <= {1'b0, r_a[W-1:1]};
            r_b      <= {1'b0, r_b[W-1:1]};
            r_d      <= {s_bit, r_d[W-1:1]};
            r_borrow <= s_borrow;
        end
    end

    assign o_done = r_done;
    assign o_diff = r_d;

endmodule

`default_nettype wire

[src/lfbc_div.sv]
// ----------------------------------------------------------------------------
// lfbc_div
// Restoring divider, one quotient bit per cycle. The upper TW bits of the
// numerator must be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbc_div #(
    parameter int TW = 16,
    parameter int AW = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [TW+AW-1:0] i_num,
    input  wire logic [TW-1:0]   i_den,
    output logic                 o_done,
    output logic [AW-1:0]        o_quot
);

    localparam int CNT_W = $clog2(AW + 1);

    logic [TW-1:0]    r_rem;
    logic [AW-1:0]    r_low;
    logic [AW-1:0]    r_quot;
    logic [TW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [TW:0]      s_trial;
    logic [TW:0]      s_diff;
    logic             s_ge;

    assign s_trial = {r_rem, r_low[AW-1]};
    assign s_diff  = s_trial - {1'b0, r_den};
    assign s_ge    = (s_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(AW);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[TW+AW-1:AW];
            r_low <= i_num[AW-1:0];
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem  <= s_ge ? s_diff[TW-1:0] : s_trial[TW-1:0];
            r_low  <= {r_low[AW-2:0], 1'b0};
            r_quot <= {r_quot[AW-2:0], s_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[src/led_blink_fade_controller.sv]
// ----------------------------------------------------------------------------
// led_blink_fade_controller
// Blink and fade sequencer driven by elapsed-time updates.
// ----------------------------------------------------------------------------
// Each request carries the ticks elapsed since the previous one and yields one
// result: the phase after the update and, when the update sets a new opacity,
// the alpha value. The countdown is subtracted bit-serially; a ramp update in a
// fading phase then runs a restoring divider unless the ramp saturates or the
// fade duration is zero. A new request is accepted only after the previous one
// has been written to the output register, though it is taken while that result
// still waits there.
// Writing any register restarts the sequence at the visible phase.
`default_nettype none

module led_blink_fade_controller
    import lfbc_pkg::*;
#(
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int ALPHA_WIDTH = ALPHA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [TIME_WIDTH-1:0] i_cfg_data,
    // update request
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [TIME_WIDTH-1:0] i_elapsed_ticks,
    // result
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [ALPHA_WIDTH-1:0]     o_alpha,
    output logic                       o_alpha_written,
    output logic [1:0]                 o_phase
);

    localparam int TW = TIME_WIDTH;
    localparam int AW = ALPHA_WIDTH;
    localparam logic [AW-1:0] ALPHA_MAX = '1;

    t_state        r_state, n_state;
    logic          r_mode, n_mode;
    logic [TW-1:0] r_vis, n_vis;
    logic [TW-1:0] r_inv, n_inv;
    logic [TW-1:0] r_fin, n_fin;
    logic [TW-1:0] r_fout, n_fout;
    t_phase        r_phase, n_phase;
    logic [TW:0]   r_remain, n_remain;
    logic [AW-1:0] r_ramp, n_ramp;
    logic          r_out_valid, n_out_valid;
    logic [AW-1:0] r_alpha, n_alpha;
    logic          r_written, n_written;
    t_phase        r_out_phase, n_out_phase;

    logic             sub_start;
    logic             sub_done;
    logic [TW:0]      sub_diff;
    logic             div_start;
    logic             div_done;
    logic [AW-1:0]    div_quot;
    logic [TW-1:0]    cnt_u;
    logic             cnt_pos;
    logic [TW-1:0]    ramp_den;
    logic [TW+AW-1:0] div_num;

    assign cnt_u    = sub_diff[TW-1:0];
    assign cnt_pos  = !sub_diff[TW] && (sub_diff != '0);
    assign ramp_den = (r_phase == PH_FADE_OUT) ? r_fout : r_fin;
    // count * (2^AW - 1)
    assign div_num  = {cnt_u, {AW{1'b0}}} - {{AW{1'b0}}, cnt_u};

    lfbc_sersub #(
        .W (TW + 1)
    ) u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sub_start),
        .i_a     (r_remain),
        .i_b     ({1'b0, i_elapsed_ticks}),
        .o_done  (sub_done),
        .o_diff  (sub_diff)
    );

    lfbc_div #(
        .TW (TW),
        .AW (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (ramp_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        logic restart;
        n_state     = r_state;
        n_mode      = r_mode;
        n_vis       = r_vis;
        n_inv       = r_inv;
        n_fin       = r_fin;
        n_fout      = r_fout;
        n_phase     = r_phase;
        n_remain    = r_remain;
        n_ramp      = r_ramp;
        n_out_valid = r_out_valid && !i_ready;
        n_alpha     = r_alpha;
        n_written   = r_written;
        n_out_phase = r_out_phase;
        sub_start   = 1'b0;
        div_start   = 1'b0;
        o_ready     = 1'b0;
        restart     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    sub_start = 1'b1;
                    n_state   = ST_SUB;
                end
            end
            ST_SUB: begin
                if (sub_done) begin
                    n_state = ST_DONE;
                    if (cnt_pos && r_mode &&
                        (r_phase == PH_FADE_OUT || r_phase == PH_FADE_IN)) begin
                        if (ramp_den == '0) begin
                            n_ramp = '0;
                        end else if (cnt_u > ramp_den) begin
                            n_ramp = ALPHA_MAX;
                        end else begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_ramp  = div_quot;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_alpha     = '0;
                    n_written   = 1'b0;
                    n_remain    = sub_diff;
                    if (cnt_pos) begin
                        if (r_mode && r_phase == PH_FADE_OUT) begin
                            n_alpha   = r_ramp;
                            n_written = 1'b1;
                        end else if (r_mode && r_phase == PH_FADE_IN) begin
                            n_alpha   = ALPHA_MAX - r_ramp;
                            n_written = 1'b1;
                        end
                    end else if (!r_mode) begin
                        // plain toggling; a fading phase holds its place
                        if (r_phase == PH_VISIBLE) begin
                            n_phase   = PH_INVISIBLE;
                            n_remain  = {1'b0, r_inv};
                            n_written = 1'b1;
                        end else if (r_phase == PH_INVISIBLE) begin
                            n_phase   = PH_VISIBLE;
                            n_remain  = {1'b0, r_vis};
                            n_alpha   = ALPHA_MAX;
                            n_written = 1'b1;
                        end
                    end else begin
                        unique case (r_phase)
                            PH_VISIBLE: begin
                                n_phase  = PH_FADE_OUT;
                                n_remain = {1'b0, r_fout};
                            end
                            PH_FADE_OUT: begin
                                n_phase   = PH_INVISIBLE;
                                n_remain  = {1'b0, r_inv};
                                n_written = 1'b1;
                            end
                            PH_INVISIBLE: begin
                                n_phase  = PH_FADE_IN;
                                n_remain = {1'b0, r_fin};
                            end
                            default: begin
                                n_phase   = PH_VISIBLE;
                                n_remain  = {1'b0, r_vis};
                                n_alpha   = ALPHA_MAX;
                                n_written = 1'b1;
                            end
                        endcase
                    end
                    n_out_phase = n_phase;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (i_cfg_we) begin
            restart = 1'b1;
            unique case (i_cfg_index)
                CFG_BLINK_MODE:    n_mode = i_cfg_data[0];
                CFG_VISIBLE_DUR:   n_vis  = i_cfg_data;
                CFG_INVISIBLE_DUR: n_inv  = i_cfg_data;
                CFG_FADE_IN_DUR:   n_fin  = i_cfg_data;
                CFG_FADE_OUT_DUR:  n_fout = i_cfg_data;
                default:           restart = 1'b0;
            endcase
            if (restart) begin
                n_phase  = PH_VISIBLE;
                n_remain = {1'b0, n_vis};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= 1'b0;
            r_vis       <= TW'(VISIBLE_RESET);
            r_inv       <= TW'(INVISIBLE_RESET);
            r_fin       <= TW'(FADE_IN_RESET);
            r_fout      <= TW'(FADE_OUT_RESET);
            r_phase     <= PH_VISIBLE;
            r_remain    <= (TW + 1)'(VISIBLE_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_vis       <= n_vis;
            r_inv       <= n_inv;
            r_fin       <= n_fin;
            r_fout      <= n_fout;
            r_phase     <= n_phase;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ramp      <= n_ramp;
        r_alpha     <= n_alpha;
        r_written   <= n_written;
        r_out_phase <= n_out_phase;
    end

    assign o_valid         = r_out_valid;
    assign o_alpha         = r_alpha;
    assign o_alpha_written = r_written;
    assign o_phase         = r_out_phase;

endmodule

`default_nettype wire
